/* rtl/mvw_pkg.sv */
// Package for the mesh vertex weld indexer: payload structs, limits, codes
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package mvw_pkg;

  localparam int unsigned MAX_VERTS   = 4096;
  localparam int unsigned MAX_CORNERS = 16384;

  localparam int unsigned VADDR_W = $clog2(MAX_VERTS);
  localparam int unsigned UNIQ_W  = $clog2(MAX_VERTS + 1);
  localparam int unsigned KEPT_W  = $clog2(MAX_CORNERS + 1);
  localparam int unsigned KEY_W   = 48;
  localparam int unsigned IDX_W   = 16;

  localparam logic CFG_POSITION_COUNT = 1'b0;
  localparam logic CFG_TEXCOORD_COUNT = 1'b1;

  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FEW_IDX   = 2'd1;
  localparam logic [1:0] STATUS_MANY_VERT = 2'd2;
  localparam logic [1:0] STATUS_MANY_IDX  = 2'd3;

  typedef struct packed {
    logic [15:0]        position_index;
    logic [15:0]        texcoord_index;
    logic signed [15:0] s_raw;
    logic signed [15:0] t_raw;
    logic               final_corner;
  } mvw_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [11:0] vertex_number;
    logic        is_new_vertex;
    logic [15:0] source_position;
    logic [15:0] source_texcoord;
    logic [1:0]  status;
    logic [14:0] kept_corners;
    logic [12:0] unique_vertices;
    logic        last_of_run;
  } mvw_res_t;

  typedef struct packed {
    logic       accept;
    logic       search;
    logic       search_init;
    logic       end_rec;
    logic [1:0] corner;
  } mvw_cmd_t;

  typedef struct packed {
    logic weld_go;
    logic in_final;
    logic found;
    logic final_q;
  } mvw_sts_t;

endpackage

/* rtl/mvw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mvw_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mvw_ctrl.sv */
// Controller state machine of the weld indexer: sequences accept, the
// per-corner table search and the end record. Depends on mvw_pkg.
`timescale 1ns / 1ps

module mvw_ctrl import mvw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  mvw_sts_t sts_i,
  output mvw_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_END    = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] corner_q, corner_d;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    cmd_o    = '0;
    cmd_o.corner = corner_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (sts_i.weld_go) begin
            cmd_o.search_init = 1'b1;
            corner_d = 2'd0;
            state_d  = ST_SEARCH;
          end else if (sts_i.in_final) begin
            state_d = ST_END;
          end
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.found) begin
          if (corner_q == 2'd2) begin
            state_d = sts_i.final_q ? ST_END : ST_IDLE;
          end else begin
            cmd_o.search_init = 1'b1;
            corner_d = corner_q + 2'd1;
          end
        end
      end
      ST_END: begin
        cmd_o.end_rec = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      corner_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

endmodule

/* rtl/mvw_dpath.sv */
// Datapath of the weld indexer: count registers, triangle assembly, the
// unique-vertex table search and the result register.
// Depends on mvw_pkg and mvw_ram.
`timescale 1ns / 1ps

module mvw_dpath import mvw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mvw_cmd_t    cmd_i,
  output mvw_sts_t    sts_o,
  input  mvw_in_t     in_i,
  input  logic        wr_en_i,
  input  logic        wr_idx_i,
  input  logic [15:0] wr_data_i,
  output logic        res_valid_o,
  output mvw_res_t    res_o
);

  logic [IDX_W-1:0]  pos_cnt_q, tc_cnt_q;
  logic [UNIQ_W-1:0] uniq_q, uniq_d;
  logic [KEPT_W-1:0] kept_q, kept_d;
  logic [1:0]        phase_q, phase_d;
  logic              tri_bad_q, tri_bad_d;
  logic [1:0]        ovf_q, ovf_d;
  logic              fin_q;
  logic [63:0]       pend_q [2];
  logic [63:0]       cur_q;
  logic [UNIQ_W-1:0] rd_idx_q, rd_idx_d;
  logic [VADDR_W-1:0] cmp_idx_q;
  logic              cmp_vld_q, cmp_vld_d;
  logic              res_valid_q, res_valid_d;
  mvw_res_t          res_q, res_d;

  logic [63:0]       in_word;
  logic              in_bad, bad_all, tri_ok;
  logic [KEPT_W:0]   kept_plus3;
  logic              kept_fits;
  logic [63:0]       sel_word;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  ram_rdata;
  logic              hit, miss, issue, ram_we;

  assign in_word = {in_i.position_index, in_i.texcoord_index, in_i.s_raw, in_i.t_raw};
  assign in_bad  = (in_i.position_index >= pos_cnt_q) || (in_i.texcoord_index >= tc_cnt_q);
  assign bad_all = tri_bad_q | in_bad;
  assign kept_plus3 = {1'b0, kept_q} + (KEPT_W + 1)'(3);
  assign kept_fits  = (kept_plus3 <= (KEPT_W + 1)'(MAX_CORNERS));
  assign tri_ok     = (phase_q == 2'd2) && !bad_all && (ovf_q == STATUS_OK);

  always_comb begin
    case (cmd_i.corner)
      2'd0:    sel_word = pend_q[0];
      2'd1:    sel_word = pend_q[1];
      default: sel_word = cur_q;
    endcase
  end
  assign key = {sel_word[63:48], sel_word[31:0]};

  assign hit   = cmp_vld_q && (ram_rdata == key);
  assign miss  = !cmp_vld_q && (rd_idx_q >= uniq_q);
  assign issue = cmd_i.search && !hit && !miss && (rd_idx_q < uniq_q);
  assign ram_we = cmd_i.search && miss && (uniq_q < UNIQ_W'(MAX_VERTS));

  assign sts_o.weld_go  = tri_ok && kept_fits;
  assign sts_o.in_final = in_i.final_corner;
  assign sts_o.found    = hit || miss;
  assign sts_o.final_q  = fin_q;

  mvw_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_VERTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (uniq_q[VADDR_W-1:0]),
    .wdata_i (key),
    .re_i    (issue),
    .raddr_i (rd_idx_q[VADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    uniq_d      = uniq_q;
    kept_d      = kept_q;
    phase_d     = phase_q;
    tri_bad_d   = tri_bad_q;
    ovf_d       = ovf_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (cmd_i.accept) begin
      if (phase_q != 2'd2) begin
        phase_d   = phase_q + 2'd1;
        tri_bad_d = bad_all;
      end else begin
        phase_d   = 2'd0;
        tri_bad_d = 1'b0;
        if (tri_ok && !kept_fits) begin
          ovf_d = STATUS_MANY_IDX;
        end
      end
    end

    if (cmd_i.search) begin
      if (hit || miss) begin
        res_d = '0;
        res_d.record_kind     = KIND_CORNER;
        res_d.source_position = sel_word[63:48];
        res_d.source_texcoord = sel_word[47:32];
        res_d.status          = STATUS_OK;
        res_d.last_of_run     = (cmd_i.corner == 2'd2) && !fin_q;
        if (hit) begin
          res_d.vertex_number = 12'(cmp_idx_q);
        end else if (ram_we) begin
          res_d.vertex_number = 12'(uniq_q);
          res_d.is_new_vertex = 1'b1;
          uniq_d = uniq_q + UNIQ_W'(1);
        end else if (ovf_q == STATUS_OK) begin
          ovf_d = STATUS_MANY_VERT;
        end
        kept_d = kept_q + KEPT_W'(1);
        res_d.kept_corners    = 15'(kept_d);
        res_d.unique_vertices = 13'(uniq_d);
        res_valid_d = 1'b1;
      end else begin
        cmp_vld_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + UNIQ_W'(1);
        end
      end
    end

    if (cmd_i.search_init) begin
      rd_idx_d  = '0;
      cmp_vld_d = 1'b0;
    end

    if (cmd_i.end_rec) begin
      res_d = '0;
      res_d.record_kind     = KIND_END;
      res_d.status          = (kept_q < KEPT_W'(3)) ? STATUS_FEW_IDX : ovf_q;
      res_d.kept_corners    = 15'(kept_q);
      res_d.unique_vertices = 13'(uniq_q);
      res_d.last_of_run     = 1'b1;
      res_valid_d = 1'b1;
      uniq_d    = '0;
      kept_d    = '0;
      phase_d   = 2'd0;
      tri_bad_d = 1'b0;
      ovf_d     = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_cnt_q   <= '0;
      tc_cnt_q    <= '0;
      uniq_q      <= '0;
      kept_q      <= '0;
      phase_q     <= 2'd0;
      tri_bad_q   <= 1'b0;
      ovf_q       <= STATUS_OK;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (wr_en_i && (wr_idx_i == CFG_POSITION_COUNT)) begin
        pos_cnt_q <= wr_data_i;
      end
      if (wr_en_i && (wr_idx_i == CFG_TEXCOORD_COUNT)) begin
        tc_cnt_q <= wr_data_i;
      end
      uniq_q      <= uniq_d;
      kept_q      <= kept_d;
      phase_q     <= phase_d;
      tri_bad_q   <= tri_bad_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (issue) begin
      cmp_idx_q <= rd_idx_q[VADDR_W-1:0];
    end
    if (cmd_i.accept) begin
      cur_q <= in_word;
      fin_q <= in_i.final_corner;
      if (phase_q != 2'd2) begin
        pend_q[phase_q[0]] <= in_word;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/mesh_vertex_weld_indexer_unit.sv */
// A kept triangle's corners are searched one after another against the
// table of unique vertices held, one table entry read per cycle; a final
// corner then adds an end record. Records are registered and leave in the
// cycle after they are formed, one per strobe; the receiver cannot stall.
// Reset clears the count registers, model state and configuration; the
// table contents are not cleared.
`timescale 1ns / 1ps

module mesh_vertex_weld_indexer_unit import mvw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  mvw_in_t     in_i,
  output logic        res_valid_o,
  output mvw_res_t    res_o,
  input  logic        wr_en_i,
  input  logic        wr_idx_i,
  input  logic [15:0] wr_data_i
);

  mvw_cmd_t cmd;
  mvw_sts_t sts;
  logic     busy_w;

  mvw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy_w),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mvw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .wr_en_i     (wr_en_i),
    .wr_idx_i    (wr_idx_i),
    .wr_data_i   (wr_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy = busy_w;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.record_kind == KIND_END)) |-> res_o.last_of_run)
    else $error("end record not marked last of run");

  a_new_vertex_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.record_kind == KIND_CORNER) && res_o.is_new_vertex) |->
    ({1'b0, res_o.vertex_number} == (res_o.unique_vertices - 13'd1)))
    else $error("new vertex number does not match unique count");

  a_beat_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_w))
    else $error("result beat without preceding busy cycle");

  a_search_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.search || cmd.end_rec) |-> (busy_w && !cmd.accept))
    else $error("search or end command while idle");

endmodule

/* dv/tb_mesh_vertex_weld_indexer_unit.sv */
// Self-checking bench for mesh_vertex_weld_indexer_unit: drives corner beats and register
// writes, predicts welded corner and end records and compares them field by field.
// Depends on mvw_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_mesh_vertex_weld_indexer_unit import mvw_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned SETTLE      = 16;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        reg_idx;
    logic [15:0] reg_val;
    mvw_in_t     beat;
    logic        typed;
    logic [1:0]  want_status;
  } plan_row_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        start     = 1'b0;
  logic        wr_en_i   = 1'b0;
  logic        wr_idx_i  = 1'b0;
  logic [15:0] wr_data_i = '0;
  mvw_in_t     in_i      = '0;
  logic        busy;
  logic        res_valid_o;
  mvw_res_t    res_o;

  logic [15:0]      pos_limit;
  logic [15:0]      tex_limit;
  logic [KEY_W-1:0] weld_keys [MAX_VERTS];
  int unsigned      weld_count;
  int unsigned      kept_total;
  mvw_in_t          held_corner [2];
  int unsigned      corner_slot;
  bit               tri_bad;
  logic [1:0]       ovf_code;

  mvw_res_t    due_records [$];
  plan_row_t   plan [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  mesh_vertex_weld_indexer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .wr_en_i     (wr_en_i),
    .wr_idx_i    (wr_idx_i),
    .wr_data_i   (wr_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_model();
    weld_count  = 0;
    kept_total  = 0;
    corner_slot = 0;
    tri_bad     = 1'b0;
    ovf_code    = STATUS_OK;
  endfunction

  function automatic mvw_res_t weld_vertex(input mvw_in_t c);
    logic [KEY_W-1:0] key;
    mvw_res_t         r;
    bit               hit;
    key = {c.position_index, c.s_raw, c.t_raw};
    r   = '0;
    hit = 1'b0;
    for (int unsigned i = 0; i < weld_count && !hit; i++) begin
      if (weld_keys[i] == key) begin
        r.vertex_number = 12'(i);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (weld_count < MAX_VERTS) begin
        weld_keys[weld_count] = key;
        r.vertex_number = 12'(weld_count);
        r.is_new_vertex = 1'b1;
        weld_count++;
      end else if (ovf_code == STATUS_OK) begin
        ovf_code = STATUS_MANY_VERT;
      end
    end
    kept_total++;
    r.record_kind     = KIND_CORNER;
    r.source_position = c.position_index;
    r.source_texcoord = c.texcoord_index;
    r.status          = STATUS_OK;
    r.kept_corners    = 15'(kept_total);
    r.unique_vertices = 13'(weld_count);
    return r;
  endfunction

  task automatic predict_weld(input mvw_in_t c, input bit keep);
    mvw_res_t recs [4];
    mvw_res_t r;
    int       n;
    n = 0;
    if (c.position_index >= pos_limit || c.texcoord_index >= tex_limit) tri_bad = 1'b1;
    if (corner_slot < 2) begin
      held_corner[corner_slot] = c;
      corner_slot++;
    end else begin
      if (!tri_bad && ovf_code == STATUS_OK) begin
        if (kept_total + 3 > MAX_CORNERS) begin
          ovf_code = STATUS_MANY_IDX;
        end else begin
          recs[0] = weld_vertex(held_corner[0]);
          recs[1] = weld_vertex(held_corner[1]);
          recs[2] = weld_vertex(c);
          n = 3;
        end
      end
      corner_slot = 0;
      tri_bad     = 1'b0;
    end
    if (c.final_corner) begin
      r = '0;
      r.record_kind     = KIND_END;
      r.status          = (kept_total < 3) ? STATUS_FEW_IDX : ovf_code;
      r.kept_corners    = 15'(kept_total);
      r.unique_vertices = 13'(weld_count);
      recs[n] = r;
      n++;
      clear_model();
    end
    if (n > 0) recs[n-1].last_of_run = 1'b1;
    if (keep) begin
      for (int k = 0; k < n; k++) due_records.push_back(recs[k]);
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_record(input mvw_res_t got);
    mvw_res_t want;
    if (due_records.size() == 0) begin
      $error("record with none due: %h", got);
      error_count++;
    end else begin
      want = due_records.pop_front();
      cmp_field("record_kind", want.record_kind, got.record_kind);
      cmp_field("vertex_number", want.vertex_number, got.vertex_number);
      cmp_field("is_new_vertex", want.is_new_vertex, got.is_new_vertex);
      cmp_field("source_position", want.source_position, got.source_position);
      cmp_field("source_texcoord", want.source_texcoord, got.source_texcoord);
      cmp_field("status", want.status, got.status);
      cmp_field("kept_corners", want.kept_corners, got.kept_corners);
      cmp_field("unique_vertices", want.unique_vertices, got.unique_vertices);
      cmp_field("last_of_run", want.last_of_run, got.last_of_run);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) check_record(res_o);
  end

  function automatic mvw_in_t corner(input logic [15:0] pos, input logic [15:0] tc,
                                     input logic [15:0] s, input logic [15:0] t,
                                     input logic fin);
    mvw_in_t c;
    c.position_index = pos;
    c.texcoord_index = tc;
    c.s_raw          = s;
    c.t_raw          = t;
    c.final_corner   = fin;
    return c;
  endfunction

  task automatic send_beat(input mvw_in_t c, input bit keep);
    start <= 1'b1;
    in_i  <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_weld(c, keep);
  endtask

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_records.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    wr_en_i   <= 1'b1;
    wr_idx_i  <= idx;
    wr_data_i <= val;
    @(posedge clk_i);
    wr_en_i <= 1'b0;
    if (idx == CFG_POSITION_COUNT) pos_limit = val;
    else tex_limit = val;
  endtask

  task automatic add_beat(input logic [15:0] pos, input logic [15:0] tc,
                          input logic [15:0] s, input logic [15:0] t, input logic fin);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_BEAT;
    r.beat  = corner(pos, tc, s, t, fin);
    plan.push_back(r);
  endtask

  task automatic add_end(input logic [15:0] pos, input logic [15:0] tc,
                         input logic [1:0] status);
    plan_row_t r;
    r             = '0;
    r.kind        = ROW_BEAT;
    r.beat        = corner(pos, tc, 16'h0000, 16'h0000, 1'b1);
    r.typed       = 1'b1;
    r.want_status = status;
    plan.push_back(r);
  endtask

  task automatic add_write(input logic idx, input logic [15:0] val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endtask

  function automatic logic [15:0] pick_index(input logic [15:0] lim);
    int unsigned top;
    if (lim == 0) return 16'($urandom);
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(lim, 16'hFFFF));
    top = (lim > 6) ? 6 : lim - 1;
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, top));
    return 16'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 6))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'h7FFF;
      4:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mvw_in_t random_corner();
    if ($urandom_range(0, 9) == 0)
      return corner(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    $urandom_range(0, 3) == 0);
    return corner(pick_index(pos_limit), pick_index(tex_limit), pick_coord(), pick_coord(),
                  $urandom_range(0, 14) == 0);
  endfunction

  task automatic run_random(input logic [15:0] pc, input logic [15:0] tc,
                            input int unsigned n, input bit idle_on);
    write_reg(CFG_POSITION_COUNT, pc);
    write_reg(CFG_TEXCOORD_COUNT, tc);
    for (int unsigned k = 0; k < n; k++) begin
      if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
      if (idle_on && $urandom_range(0, 39) == 0) drain();
      send_beat(random_corner(), 1'b1);
    end
  endtask

  initial begin
    mvw_res_t want;
    pos_limit = '0;
    tex_limit = '0;
    clear_model();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone final corner while both counts are still zero
    add_end(16'h0000, 16'h0000, STATUS_FEW_IDX);
    add_write(CFG_POSITION_COUNT, 16'hFFFF);
    add_write(CFG_TEXCOORD_COUNT, 16'hFFFF);
    add_beat(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    add_beat(16'hFFFE, 16'hFFFE, 16'h7FFF, 16'h8000, 1'b0);
    add_beat(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    add_beat(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'h0002, 16'h0002, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'h0005, 16'h0005, 16'h0001, 16'h0001, 1'b0);
    add_beat(16'h0005, 16'h0006, 16'h0001, 16'h0001, 1'b0);
    add_beat(16'h0005, 16'h0005, 16'h0001, 16'h0002, 1'b1);
    // partial triangles dropped at the end of a model
    add_end(16'h0003, 16'h0003, STATUS_FEW_IDX);
    add_beat(16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b0);
    add_end(16'h0002, 16'h0002, STATUS_FEW_IDX);
    add_write(CFG_POSITION_COUNT, 16'd16);
    add_write(CFG_TEXCOORD_COUNT, 16'd8);
    add_beat(16'd15, 16'd7, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd16, 16'd0, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd0, 16'd0, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd0, 16'd8, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd1, 16'd1, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd2, 16'd2, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd15, 16'd7, 16'hFFFF, 16'hFFFF, 1'b0);
    add_beat(16'd0, 16'd0, 16'h0000, 16'h0000, 1'b0);
    add_beat(16'd3, 16'd3, 16'h0000, 16'h0000, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 15));
        send_beat(plan[i].beat, !plan[i].typed);
        if (plan[i].typed) begin
          want             = '0;
          want.record_kind = KIND_END;
          want.status      = plan[i].want_status;
          want.last_of_run = 1'b1;
          due_records.push_back(want);
        end
      end
    end

    run_random(16'h0000, 16'hFFFF, 25, 1'b1);
    run_random(16'h0001, 16'h8000, 25, 1'b1);
    run_random(16'hFFFF, 16'hFFFF, 30, 1'b1);
    run_random(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)), 30, 1'b0);

    drain();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
